// ===== sv/lam_pkg.sv =====
// Package for the LFO amplitude modulator: waveform codes, register indexes,
// state layout constants and the quarter-wave sine table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lam_pkg;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_SAW      = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_type;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAVEFORM  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PHASE_INC = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WRAP      = 2'd2;

   localparam int CSR_DATA_BITS = 32;
   localparam int PHASE_BITS    = 32;
   localparam int COUNT_BITS    = 18;
   localparam int WRAP_BITS     = 19;
   localparam int STATE_BITS    = PHASE_BITS + COUNT_BITS;
   localparam int LFO_BITS      = 17;
   localparam int Q_SHIFT       = 15;
   localparam int SINE_BITS     = 15;

   localparam logic [WRAP_BITS-1:0]  MAX_WRAP       = 19'd262144;
   localparam logic [WRAP_BITS-1:0]  RESET_WRAP     = 19'd48000;
   localparam logic [PHASE_BITS-1:0] RESET_PHASE_INC = 32'd89478;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic [COUNT_BITS-1:0] count;
   } chan_state_type;

   function automatic logic [SINE_BITS-1:0] quarter_sine(input logic [6:0] k);
      logic [SINE_BITS-1:0] s;
      case (k)
         7'd0:  s = 15'd0;     7'd1:  s = 15'd402;   7'd2:  s = 15'd804;
         7'd3:  s = 15'd1205;  7'd4:  s = 15'd1606;  7'd5:  s = 15'd2006;
         7'd6:  s = 15'd2404;  7'd7:  s = 15'd2801;  7'd8:  s = 15'd3196;
         7'd9:  s = 15'd3590;  7'd10: s = 15'd3981;  7'd11: s = 15'd4370;
         7'd12: s = 15'd4756;  7'd13: s = 15'd5139;  7'd14: s = 15'd5520;
         7'd15: s = 15'd5897;  7'd16: s = 15'd6270;  7'd17: s = 15'd6639;
         7'd18: s = 15'd7005;  7'd19: s = 15'd7366;  7'd20: s = 15'd7723;
         7'd21: s = 15'd8076;  7'd22: s = 15'd8423;  7'd23: s = 15'd8765;
         7'd24: s = 15'd9102;  7'd25: s = 15'd9434;  7'd26: s = 15'd9760;
         7'd27: s = 15'd10080; 7'd28: s = 15'd10394; 7'd29: s = 15'd10702;
         7'd30: s = 15'd11003; 7'd31: s = 15'd11297; 7'd32: s = 15'd11585;
         7'd33: s = 15'd11866; 7'd34: s = 15'd12140; 7'd35: s = 15'd12406;
         7'd36: s = 15'd12665; 7'd37: s = 15'd12916; 7'd38: s = 15'd13160;
         7'd39: s = 15'd13395; 7'd40: s = 15'd13623; 7'd41: s = 15'd13842;
         7'd42: s = 15'd14053; 7'd43: s = 15'd14256; 7'd44: s = 15'd14449;
         7'd45: s = 15'd14635; 7'd46: s = 15'd14811; 7'd47: s = 15'd14978;
         7'd48: s = 15'd15137; 7'd49: s = 15'd15286; 7'd50: s = 15'd15426;
         7'd51: s = 15'd15557; 7'd52: s = 15'd15679; 7'd53: s = 15'd15791;
         7'd54: s = 15'd15893; 7'd55: s = 15'd15986; 7'd56: s = 15'd16069;
         7'd57: s = 15'd16143; 7'd58: s = 15'd16207; 7'd59: s = 15'd16261;
         7'd60: s = 15'd16305; 7'd61: s = 15'd16340; 7'd62: s = 15'd16364;
         7'd63: s = 15'd16379; 7'd64: s = 15'd16384;
         default: s = 15'd0;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== sv/lfo_amplitude_modulator.sv =====
// Multiplies each sample by its channel's oscillator value, rounds and saturates.
// One transaction per cycle is sustained unless rsp_ready stalls the output. Stages:
// state read with oscillator and state update, multiply, round and saturate.
// Per-channel phase and counter live in a one-port-read, one-port-write RAM; a write
// that overlaps the next read of the same channel is forwarded. No clearing pass.
// Depends on lam_pkg, lam_ram and lam_osc.
`timescale 1ns / 1ps
`default_nettype none
module lfo_amplitude_modulator #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_ready,
   input  wire logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] req_channel_index,
   input  wire logic signed [SAMPLE_BITS-1:0]              req_sample_in,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]                   rsp_sample_out,
   output logic signed [lam_pkg::LFO_BITS-1:0]             rsp_lfo_value,
   input  wire logic                                       csr_valid,
   output logic                                            csr_ready,
   input  wire logic [lam_pkg::CSR_IDX_BITS-1:0]           csr_index,
   input  wire logic [lam_pkg::CSR_DATA_BITS-1:0]          csr_data
);
   import lam_pkg::*;

   localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PROD_BITS = SAMPLE_BITS + LFO_BITS;
   localparam int RND_BITS  = PROD_BITS + 1;
   localparam int Y_BITS    = RND_BITS - Q_SHIFT;

   // configuration
   wave_type              waveform_ff;
   logic [PHASE_BITS-1:0] phase_inc_ff;
   logic [WRAP_BITS-1:0]  wrap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff  <= WAVE_SINE;
         phase_inc_ff <= RESET_PHASE_INC;
         wrap_ff      <= RESET_WRAP;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WAVEFORM:  waveform_ff  <= wave_type'(csr_data[1:0]);
            CSR_PHASE_INC: phase_inc_ff <= csr_data[PHASE_BITS-1:0];
            CSR_WRAP:      wrap_ff      <= csr_data[WRAP_BITS-1:0];
            default:       ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // pipeline control
   logic advance;
   logic accept;
   logic out_valid_ff;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   logic [CH_BITS-1:0] req_addr;
   always_comb begin
      if ({1'b0, req_channel_index} >= (CH_BITS + 1)'(CHANNELS)) begin
         req_addr = CH_BITS'(CHANNELS - 1);
      end else begin
         req_addr = req_channel_index;
      end
   end

   // stage 1: state read
   logic                          s1_valid_ff;
   logic [CH_BITS-1:0]            s1_ch_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                          s1_entry_ok_ff;
   logic [CHANNELS-1:0]           entry_valid_ff;
   logic [CHANNELS-1:0]           entry_valid_in;
   logic                          fwd_valid_ff;
   logic [CH_BITS-1:0]            fwd_ch_ff;
   chan_state_type                fwd_data_ff;
   logic [STATE_BITS-1:0]         rd_data;
   chan_state_type                cur_state;
   chan_state_type                new_state;
   logic                          wr_en;
   logic [WRAP_BITS-1:0]          wrap_eff;
   logic [WRAP_BITS-1:0]          count_next;
   logic signed [LFO_BITS-1:0]    lfo;

   lam_ram #(
      .WIDTH (STATE_BITS),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ch_ff),
      .wr_data (new_state),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (fwd_valid_ff && (fwd_ch_ff == s1_ch_ff)) begin
         cur_state = fwd_data_ff;
      end else if (s1_entry_ok_ff) begin
         cur_state = chan_state_type'(rd_data);
      end else begin
         cur_state = '0;
      end
      if (wrap_ff == '0) begin
         wrap_eff = WRAP_BITS'(1);
      end else if (wrap_ff > MAX_WRAP) begin
         wrap_eff = MAX_WRAP;
      end else begin
         wrap_eff = wrap_ff;
      end
      count_next = {1'b0, cur_state.count} + WRAP_BITS'(1);
      if (count_next >= wrap_eff) begin
         new_state = '0;
      end else begin
         new_state.phase = cur_state.phase + phase_inc_ff;
         new_state.count = count_next[COUNT_BITS-1:0];
      end
      wr_en = advance && s1_valid_ff;
      entry_valid_in = entry_valid_ff;
      if (wr_en) begin
         entry_valid_in[s1_ch_ff] = 1'b1;
      end
   end

   lam_osc u_osc (
      .waveform (waveform_ff),
      .phase    (cur_state.phase),
      .lfo      (lfo)
   );

   // stages 2 and 3: multiply, then round and saturate
   logic                          s2_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s2_sample_ff;
   logic signed [LFO_BITS-1:0]    s2_lfo_ff;
   logic                          s3_valid_ff;
   logic signed [PROD_BITS-1:0]   s3_prod_ff;
   logic signed [LFO_BITS-1:0]    s3_lfo_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic signed [LFO_BITS-1:0]    out_lfo_ff;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic signed [RND_BITS-1:0]    rounded;
   logic signed [Y_BITS-1:0]      scaled;
   logic signed [SAMPLE_BITS-1:0] sat_in;

   always_comb begin
      prod_in = PROD_BITS'(s2_sample_ff) * PROD_BITS'(s2_lfo_ff);
      rounded = RND_BITS'(s3_prod_ff) + RND_BITS'(1 << (Q_SHIFT - 1));
      scaled  = rounded[RND_BITS-1:Q_SHIFT];
      // overflow when the bits above the sample sign disagree
      if (scaled[Y_BITS-1:SAMPLE_BITS-1] == '0 || scaled[Y_BITS-1:SAMPLE_BITS-1] == '1) begin
         sat_in = scaled[SAMPLE_BITS-1:0];
      end else if (scaled[Y_BITS-1]) begin
         sat_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         if (advance) begin
            s1_valid_ff  <= accept;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            out_valid_ff <= s3_valid_ff;
            fwd_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ch_ff       <= req_addr;
         s1_sample_ff   <= req_sample_in;
         s1_entry_ok_ff <= entry_valid_ff[req_addr];
         fwd_ch_ff      <= s1_ch_ff;
         fwd_data_ff    <= new_state;
         s2_sample_ff   <= s1_sample_ff;
         s2_lfo_ff      <= lfo;
         s3_prod_ff     <= prod_in;
         s3_lfo_ff      <= s2_lfo_ff;
         out_sample_ff  <= sat_in;
         out_lfo_ff     <= s3_lfo_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_lfo_value  = out_lfo_ff;

endmodule
`default_nettype wire

// ===== sv/lam_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/lam_osc.sv =====
// Oscillator value from a phase: sine, square, sawtooth or triangle in Q2.15.
// Depends on lam_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lam_osc (
   input  wire lam_pkg::wave_type                 waveform,
   input  wire logic [lam_pkg::PHASE_BITS-1:0]    phase,
   output logic signed [lam_pkg::LFO_BITS-1:0]    lfo
);
   import lam_pkg::*;

   logic [1:0]           quad;
   logic [6:0]           tab_idx;
   logic [SINE_BITS-1:0] sine_mag;
   logic [LFO_BITS-1:0]  sine_val;
   logic [LFO_BITS-1:0]  saw_val;
   logic [LFO_BITS+1:0]  p15;
   logic [LFO_BITS+1:0]  tri_val;

   always_comb begin
      quad     = phase[31:30];
      tab_idx  = quad[0] ? (7'd64 - {1'b0, phase[29:24]}) : {1'b0, phase[29:24]};
      sine_mag = quarter_sine(tab_idx);
      sine_val = quad[1] ? (17'd16384 - {2'b00, sine_mag})
                         : (17'd16384 + {2'b00, sine_mag});
      saw_val  = {1'b0, phase[31:16]} - 17'd32768;
      p15      = {2'b00, phase[31:15]};
      case (quad)
         2'd0:    tri_val = p15;
         2'd3:    tri_val = p15 - 19'd131072;
         default: tri_val = 19'd65536 - p15;
      endcase
      case (waveform)
         WAVE_SINE:     lfo = signed'(sine_val);
         WAVE_SQUARE:   lfo = phase[31] ? 17'sd0 : 17'sd32768;
         WAVE_SAW:      lfo = signed'(saw_val);
         WAVE_TRIANGLE: lfo = signed'(tri_val[LFO_BITS-1:0]);
         default:       lfo = 17'sd0;
      endcase
   end

endmodule
`default_nettype wire
